@@ src/fqkr_pkg.sv @@
// shared types and constants for the fifo queue with keyed removal
package fqkr_pkg;

  localparam int DEPTH = 16;
  localparam int VAL_W = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int FUNC_W = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_OUT_W = 5;
  localparam int IN_W = 40;
  localparam int OUT_W = 40;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH   = 2'd0,
    FUNC_POP    = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_RSVD = 2'd3
  } status_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic             push;
    logic             pop;
    logic             remove;
    logic [VAL_W-1:0] key;
  } ctl_t;

endpackage

@@ src/fqkr_cell.sv @@
// one queue slot: holds a value, compares it with the key, shifts toward the head
module fqkr_cell (
  input  logic                       clk,
  input  fqkr_pkg::ctl_t             ctl,
  input  logic                       valid,
  input  logic                       is_tail,
  input  logic [fqkr_pkg::VAL_W-1:0] next_value,
  input  logic                       match_in,
  output logic [fqkr_pkg::VAL_W-1:0] value,
  output logic                       match_out
);

  logic hit;
  logic shift;

  assign hit       = ctl.remove && valid && (value == ctl.key);
  assign match_out = match_in || hit;
  // a cell at or behind the removed entry takes its neighbor's value
  assign shift     = ctl.pop || (ctl.remove && match_out);

  always_ff @(posedge clk) begin
    if (ctl.push && is_tail) begin
      value <= ctl.key;
    end else if (shift) begin
      value <= next_value;
    end
  end

endmodule

@@ src/fifo_queue_with_keyed_removal.sv @@
// top level: ordered queue built from a row of cells, with a result register
// Ordered queue of up to fqkr_pkg::DEPTH 32-bit values held in a row of cells,
// slot 0 being the head. Each item pushes a value at the tail, pops the head, or
// removes the first entry equal to the value; every cell compares its entry with
// the value at once, a match flag ripples from the head, and all cells at or behind
// the match take their neighbor's value in the same cycle. One item is taken per
// clock; its result (status, head before the operation, count after) is written to an
// output register, and a new item is taken whenever that register is empty or being
// drained. s_tdata: func [1:0], value [33:2]. m_tdata: status [1:0], head_value
// [33:2], count [38:34]. Unused upper bits are zero.
module fifo_queue_with_keyed_removal (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [fqkr_pkg::IN_W-1:0] s_tdata,  // func, value
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [fqkr_pkg::OUT_W-1:0] m_tdata  // status, head_value, count
);

  localparam int D = fqkr_pkg::DEPTH;
  localparam int CW = fqkr_pkg::CNT_W;
  localparam int VW = fqkr_pkg::VAL_W;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          accept;
  fqkr_pkg::func_t   func;
  logic [VW-1:0]     key;
  fqkr_pkg::ctl_t    ctl;
  fqkr_pkg::status_t status_next;
  logic              full;
  logic              empty;
  logic              found;
  logic [VW-1:0]     head;

  logic [VW-1:0] cell_value [D];
  logic [D:0]    match_chain;

  fqkr_pkg::status_t out_status;
  logic [VW-1:0]     out_head;
  logic [CW-1:0]     out_count;
  logic [fqkr_pkg::COUNT_OUT_W-1:0] count_wide;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign func     = fqkr_pkg::func_t'(s_tdata[fqkr_pkg::FUNC_W-1:0]);
  assign key      = s_tdata[fqkr_pkg::FUNC_W +: VW];
  assign full     = (count == CW'(D));
  assign empty    = (count == '0);
  assign head     = empty ? '0 : cell_value[0];

  always_comb begin
    ctl.key    = key;
    ctl.push   = accept && (func == fqkr_pkg::FUNC_PUSH) && !full;
    ctl.pop    = accept && (func == fqkr_pkg::FUNC_POP) && !empty;
    ctl.remove = accept && (func == fqkr_pkg::FUNC_REMOVE);
  end

  assign match_chain[0] = 1'b0;
  assign found          = match_chain[D];

  for (genvar i = 0; i < D; i++) begin : g_cell
    logic [VW-1:0] nxt;
    if (i == D - 1) begin : g_last
      assign nxt = cell_value[i];
    end else begin : g_mid
      assign nxt = cell_value[i+1];
    end
    fqkr_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .valid      (CW'(i) < count),
      .is_tail    (CW'(i) == count),
      .next_value (nxt),
      .match_in   (match_chain[i]),
      .value      (cell_value[i]),
      .match_out  (match_chain[i+1])
    );
  end

  always_comb begin
    count_next  = count;
    status_next = fqkr_pkg::ST_DONE;
    case (func)
      fqkr_pkg::FUNC_PUSH: begin
        if (full) begin
          status_next = fqkr_pkg::ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      fqkr_pkg::FUNC_POP: begin
        if (empty) begin
          status_next = fqkr_pkg::ST_MISS;
        end else begin
          count_next = count - CW'(1);
        end
      end
      fqkr_pkg::FUNC_REMOVE: begin
        if (found) begin
          count_next = count - CW'(1);
        end else begin
          status_next = fqkr_pkg::ST_MISS;
        end
      end
      default: begin
        status_next = fqkr_pkg::ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= status_next;
      out_head   <= head;
      out_count  <= count_next;
    end
  end

  // count reported masked to five bits
  assign count_wide = out_count[fqkr_pkg::COUNT_OUT_W-1:0];

  assign m_tdata = {{(fqkr_pkg::OUT_W - fqkr_pkg::STATUS_W - VW
                      - fqkr_pkg::COUNT_OUT_W){1'b0}},
                    count_wide, out_head, out_status};

endmodule

@@ verif/fqkr_result_checker.sv @@
// checker for the keyed-removal fifo: tracks the queue and compares every result
`timescale 1ns / 1ps

module fqkr_result_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [fqkr_pkg::IN_W-1:0]  s_tdata,  // func, value
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [fqkr_pkg::OUT_W-1:0] m_tdata,  // status, head_value, count
  output int                         fails,
  output int                         outstanding
);

  typedef struct packed {
    fqkr_pkg::status_t                status;
    logic [fqkr_pkg::VAL_W-1:0]       head;
    logic [fqkr_pkg::COUNT_OUT_W-1:0] count;
  } outcome_t;

  logic [fqkr_pkg::VAL_W-1:0] held[$];
  outcome_t                   pending_results[$];
  outcome_t                   want;
  outcome_t                   got;
  int                         results_seen = 0;

  task automatic report_miss(input string field, input logic [31:0] wanted,
                             input logic [31:0] seen);
    $display("%0t: result %0d %s: expected %h, got %h", $time, results_seen, field,
             wanted, seen);
    fails++;
  endtask

  // applies one operation to the tracked queue and returns its result
  function automatic outcome_t apply_queue_op(input fqkr_pkg::func_t f,
                                              input logic [fqkr_pkg::VAL_W-1:0] v);
    outcome_t r;
    int       hit;
    hit = -1;
    r.status = fqkr_pkg::ST_DONE;
    r.head = (held.size() > 0) ? held[0] : '0;
    case (f)
      fqkr_pkg::FUNC_PUSH: begin
        if (held.size() >= fqkr_pkg::DEPTH) r.status = fqkr_pkg::ST_FULL;
        else held.push_back(v);
      end
      fqkr_pkg::FUNC_POP: begin
        if (held.size() == 0) r.status = fqkr_pkg::ST_MISS;
        else held.delete(0);
      end
      fqkr_pkg::FUNC_REMOVE: begin
        // only the match nearest the head goes
        for (int i = 0; i < held.size(); i++)
          if (hit < 0 && held[i] == v) hit = i;
        if (hit < 0) r.status = fqkr_pkg::ST_MISS;
        else held.delete(hit);
      end
      default: ;
    endcase
    r.count = fqkr_pkg::COUNT_OUT_W'(held.size());
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      held.delete();
      pending_results.delete();
      fails = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.status = fqkr_pkg::status_t'(m_tdata[1:0]);
        got.head = m_tdata[33:2];
        got.count = m_tdata[38:34];
        if (pending_results.size() == 0) begin
          report_miss("arrived with none pending", '0, got.head);
        end else begin
          want = pending_results.pop_front();
          if (got.status != want.status)
            report_miss("status", 32'(want.status), 32'(got.status));
          if (got.head != want.head) report_miss("head_value", want.head, got.head);
          if (got.count != want.count)
            report_miss("count", 32'(want.count), 32'(got.count));
        end
        results_seen++;
      end
      if (s_tvalid && s_tready)
        pending_results.push_back(apply_queue_op(fqkr_pkg::func_t'(s_tdata[1:0]),
                                                 s_tdata[33:2]));
    end
    outstanding <= pending_results.size();
  end

endmodule

@@ verif/tb_fifo_queue_with_keyed_removal.sv @@
// testbench top: clock, reset, stimulus and verdict for the keyed-removal fifo
`timescale 1ns / 1ps

module tb_fifo_queue_with_keyed_removal;

  localparam int RANDOM_ITEMS = 1450;
  localparam int CYCLE_LIMIT = 300000;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [fqkr_pkg::IN_W-1:0]  s_tdata = '0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [fqkr_pkg::OUT_W-1:0] m_tdata;

  int                         fails;
  int                         outstanding;
  int                         cycles = 0;
  bit                         tx_calm = 1'b0;
  bit                         rx_calm = 1'b0;
  logic [fqkr_pkg::VAL_W-1:0] recent_pushes[16];
  int                         recent_idx = 0;

  always #2 clk = ~clk;

  fifo_queue_with_keyed_removal dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  fqkr_result_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .fails       (fails),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("fifo_queue_with_keyed_removal: mismatch");
      $finish;
    end
  end

  // result side: random stall before each result, none in calm stretches
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic send_item(input fqkr_pkg::func_t f,
                           input logic [fqkr_pkg::VAL_W-1:0] v);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, v, f};
    do @(posedge clk); while (!s_tready);
    if (f == fqkr_pkg::FUNC_PUSH) begin
      recent_pushes[recent_idx] = v;
      recent_idx = (recent_idx + 1) % 16;
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [fqkr_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: return fqkr_pkg::VAL_W'($urandom_range(0, 7));
      5: return fqkr_pkg::VAL_W'(1) << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // mode 0 fills, mode 1 drains, mode 2 keeps roughly level
  function automatic fqkr_pkg::func_t pick_func(input int mode);
    int r;
    int push_pct;
    int pop_pct;
    r = $urandom_range(0, 99);
    push_pct = (mode == 0) ? 65 : (mode == 1) ? 25 : 45;
    pop_pct = (mode == 0) ? 15 : (mode == 1) ? 35 : 25;
    if (r < push_pct) return fqkr_pkg::FUNC_PUSH;
    if (r < push_pct + pop_pct) return fqkr_pkg::FUNC_POP;
    if (r < 97) return fqkr_pkg::FUNC_REMOVE;
    return fqkr_pkg::FUNC_NOP;
  endfunction

  initial begin
    int                         sent;
    int                         phase;
    int                         mode;
    int                         run_len;
    fqkr_pkg::func_t            f;
    logic [fqkr_pkg::VAL_W-1:0] v;

    foreach (recent_pushes[i]) recent_pushes[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty queue corners
    send_item(fqkr_pkg::FUNC_POP, 32'h0);
    send_item(fqkr_pkg::FUNC_REMOVE, 32'h5);
    send_item(fqkr_pkg::FUNC_NOP, 32'hFFFF_FFFF);
    // fill to the brim with extremes and a duplicate pair
    send_item(fqkr_pkg::FUNC_PUSH, 32'h0);
    send_item(fqkr_pkg::FUNC_PUSH, 32'hFFFF_FFFF);
    send_item(fqkr_pkg::FUNC_PUSH, 32'h5);
    send_item(fqkr_pkg::FUNC_PUSH, 32'h5);
    send_item(fqkr_pkg::FUNC_PUSH, 32'h8000_0000);
    for (int i = 0; i < 11; i++) send_item(fqkr_pkg::FUNC_PUSH, 32'h5555_0000 + i);
    send_item(fqkr_pkg::FUNC_PUSH, 32'h7);
    send_item(fqkr_pkg::FUNC_NOP, 32'h0);
    send_item(fqkr_pkg::FUNC_REMOVE, 32'h1234_5678);
    send_item(fqkr_pkg::FUNC_REMOVE, 32'h5);
    send_item(fqkr_pkg::FUNC_REMOVE, 32'h5555_000A);
    send_item(fqkr_pkg::FUNC_POP, 32'h0);

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 2);
      run_len = $urandom_range(40, 120);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
        f = pick_func(mode);
        v = pick_value();
        // most removes aim at something recently pushed
        if (f == fqkr_pkg::FUNC_REMOVE && $urandom_range(0, 9) < 7)
          v = recent_pushes[$urandom_range(0, 15)];
        send_item(f, v);
        sent++;
      end
      if (phase == 0 || $urandom_range(0, 1) == 1) begin
        s_tvalid <= 1'b0;
        wait_drained();
      end
      phase++;
    end

    s_tvalid <= 1'b0;
    wait_drained();
    repeat (6) @(posedge clk);
    if (fails == 0) begin
      $display("fifo_queue_with_keyed_removal: match");
    end else begin
      $display("fifo_queue_with_keyed_removal: mismatch");
    end
    $finish;
  end

endmodule
